FILE: hdl/tarr_pkg.sv
package tarr_pkg;

	localparam int PTR_W   = 5;
	localparam int QDEPTH  = 2;  // power of two: queue pointers wrap on their own
	localparam int QIDX_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	localparam logic [2:0] PORT_XP    = 3'd0;
	localparam logic [2:0] PORT_XM    = 3'd1;
	localparam logic [2:0] PORT_YP    = 3'd2;
	localparam logic [2:0] PORT_YM    = 3'd3;
	localparam logic [2:0] PORT_LOCAL = 3'd4;

	localparam logic [4:0] VC_ADAPTIVE = 5'd1;
	localparam logic [4:0] VC_H        = 5'd2;
	localparam logic [4:0] VC_L        = 5'd3;

	localparam logic [1:0] CLS_ADAPTIVE = 2'd1;
	localparam logic [1:0] CLS_ESC_H    = 2'd2;
	localparam logic [1:0] CLS_ESC_L    = 2'd3;

	typedef enum logic [2:0] {
		REG_CLASS  = 3'd0,
		REG_RX     = 3'd1,
		REG_RY     = 3'd2,
		REG_RADIUS = 3'd3,
		REG_LPC    = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [1:0] chan_class;
		logic [7:0] router_x;
		logic [7:0] router_y;
		logic [7:0] radius;
		logic [4:0] local_count;
	} cfg_t;

	typedef struct packed {
		logic [4:0] chan;
		logic [2:0] port;
	} req_t;

	// one routed header: up to four requests, count kept as count-1
	typedef struct packed {
		req_t [3:0] reqs;
		logic [1:0] last_idx;
		logic       none;
	} entry_t;

endpackage

FILE: hdl/tarr_front.sv
module tarr_front import tarr_pkg::*; #(
	parameter int COORD_WIDTH     = 8,
	parameter int MAX_LOCAL_PORTS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  cfg_t         cfg,
	input  logic [9:0]   delta_x,
	input  logic [9:0]   delta_y,
	input  logic         accept,
	output entry_t       entry
);

	localparam logic [7:0] CMASK = (COORD_WIDTH >= 8) ? 8'hFF : 8'((1 << COORD_WIDTH) - 1);

	function automatic logic stays_inside(logic [9:0] d, logic [7:0] c, logic [7:0] r);
		logic signed [11:0] dest;
		dest = signed'({{2{d[9]}}, d}) + signed'({4'b0, c});
		return !dest[11] && (dest <= signed'({4'b0, r}));
	endfunction

	logic [9:0] ax, ay;
	logic       x_done, y_done, x_move, y_move;
	logic [2:0] px, py;
	logic       in_x, in_y;
	logic [PTR_W-1:0] ptr_q, cnt, base, ptr_nxt;
	logic       is_local;
	req_t [3:0] reqs;
	logic [2:0] n;

	assign ax = delta_x[9] ? (~delta_x + 10'd1) : delta_x;
	assign ay = delta_y[9] ? (~delta_y + 10'd1) : delta_y;
	assign x_done = (ax == 10'd1);
	assign y_done = (ay == 10'd1);
	assign x_move = (ax > 10'd1);
	assign y_move = (ay > 10'd1);
	assign px = (!delta_x[9] && delta_x != 10'd0) ? PORT_XP : PORT_XM;
	assign py = (!delta_y[9] && delta_y != 10'd0) ? PORT_YP : PORT_YM;
	assign in_x = stays_inside(delta_x, cfg.router_x & CMASK, cfg.radius & CMASK);
	assign in_y = stays_inside(delta_y, cfg.router_y & CMASK, cfg.radius & CMASK);
	assign is_local = x_done && y_done;

	// round-robin consumer; a zero count behaves as one
	always_comb begin
		if (int'(cfg.local_count) > MAX_LOCAL_PORTS)
			cnt = PTR_W'(MAX_LOCAL_PORTS);
		else
			cnt = cfg.local_count;
		base = (ptr_q >= cnt) ? '0 : ptr_q;
		ptr_nxt = base + PTR_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
		end else if (accept && is_local) begin
			ptr_q <= ptr_nxt;
		end
	end

	always_comb begin
		reqs = '0;
		n = '0;
		if (is_local) begin
			reqs[0] = '{chan: ptr_nxt, port: PORT_LOCAL};
			n = 3'd1;
		end else begin
			if (x_move) begin
				reqs[n[1:0]] = '{chan: VC_ADAPTIVE, port: px};
				n = n + 3'd1;
			end
			if (y_move) begin
				reqs[n[1:0]] = '{chan: VC_ADAPTIVE, port: py};
				n = n + 3'd1;
			end
			unique case (cfg.chan_class) inside
				CLS_ADAPTIVE, CLS_ESC_H: begin
					if (x_move) begin
						reqs[n[1:0]] = '{chan: VC_H, port: px};
						n = n + 3'd1;
						if (in_x) begin
							reqs[n[1:0]] = '{chan: VC_L, port: px};
							n = n + 3'd1;
						end
					end else if (x_done && y_move) begin
						reqs[n[1:0]] = '{chan: VC_H, port: py};
						n = n + 3'd1;
						if (in_y) begin
							reqs[n[1:0]] = '{chan: VC_L, port: py};
							n = n + 3'd1;
						end
					end
				end
				CLS_ESC_L: begin
					// X escape from an L channel: L then H, no wrap check
					if (x_move) begin
						reqs[n[1:0]] = '{chan: VC_L, port: px};
						n = n + 3'd1;
						reqs[n[1:0]] = '{chan: VC_H, port: px};
						n = n + 3'd1;
					end else if (x_done && y_move) begin
						reqs[n[1:0]] = '{chan: VC_H, port: py};
						n = n + 3'd1;
						if (in_y) begin
							reqs[n[1:0]] = '{chan: VC_L, port: py};
							n = n + 3'd1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		entry.reqs = reqs;
		entry.none = (n == 3'd0);
		entry.last_idx = (n == 3'd0) ? 2'd0 : 2'(n - 3'd1);
	end

endmodule

FILE: hdl/tarr_queue.sv
module tarr_queue import tarr_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	output logic   full,
	input  logic   pop,
	output logic   head_valid,
	output entry_t head
);

	entry_t            mem_q [QDEPTH];
	logic [QIDX_W-1:0] wr_q, rd_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full = (cnt_q == QCNT_W'(QDEPTH));
	assign head_valid = (cnt_q != '0);
	assign head = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + QIDX_W'(1);
			if (pop)
				rd_q <= rd_q + QIDX_W'(1);
			if (push && !pop)
				cnt_q <= cnt_q + QCNT_W'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - QCNT_W'(1);
		end
	end

endmodule

FILE: hdl/tarr_back.sv
module tarr_back import tarr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_valid,
	input  entry_t     head,
	output logic       pop,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,
	output logic       m_tlast,
	output logic       m_tuser
);

	logic [1:0] idx_q;
	logic       load, last;
	logic       valid_q;
	req_t       req_q;
	logic       last_q, none_q;

	assign load = head_valid && (!valid_q || m_tready);
	assign last = (idx_q == head.last_idx);
	assign pop = load && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q <= '0;
		end else begin
			if (load)
				valid_q <= 1'b1;
			else if (m_tready)
				valid_q <= 1'b0;
			if (load)
				idx_q <= last ? 2'd0 : idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			req_q <= head.reqs[idx_q];
			last_q <= last;
			none_q <= head.none;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata = {req_q.chan, req_q.port};
	assign m_tlast = last_q;
	assign m_tuser = none_q;

endmodule

FILE: hdl/torus_adaptive_route_request_core.sv
// channel   dir  fields (low bit up)                       accepted when
// s_*       in   tdata: delta_x[9:0], delta_y[19:10], pad    s_tvalid & s_tready
// m_*       out  tdata: out_port[2:0], out_channel[7:3]      m_tvalid & m_tready
//                tlast: is_last, tuser: no_request
// cfg_*     in   cfg_index selects register, cfg_data value  cfg_wr_en
//
// A header is classified in the cycle it is accepted and queued (two entries).
// The back end sends its requests one per cycle from an output register unless
// m_tready stalls it, one to four per header; input takes one item a cycle
// while the queue has room. Reset clears control state and the consumer pointer.
// Either side may stall without stopping the other until the queue fills.
module torus_adaptive_route_request_core import tarr_pkg::*; #(
	parameter int COORD_WIDTH     = 8,
	parameter int MAX_LOCAL_PORTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // delta_x, delta_y, zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // out_port, out_channel
	output logic        m_tlast,
	output logic        m_tuser,   // no_request
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	cfg_t   cfg_q;
	entry_t entry, head;
	logic   full, push, pop, head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.chan_class <= CLS_ADAPTIVE;
			cfg_q.router_x <= 8'd0;
			cfg_q.router_y <= 8'd0;
			cfg_q.radius <= 8'd7;
			cfg_q.local_count <= 5'd1;
		end else if (cfg_wr_en) begin
			unique case (reg_idx_t'(cfg_index))
				REG_CLASS:  cfg_q.chan_class <= cfg_data[1:0];
				REG_RX:     cfg_q.router_x <= cfg_data;
				REG_RY:     cfg_q.router_y <= cfg_data;
				REG_RADIUS: cfg_q.radius <= cfg_data;
				REG_LPC:    cfg_q.local_count <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	assign s_tready = !full;
	assign push = s_tvalid && s_tready;

	tarr_front #(
		.COORD_WIDTH(COORD_WIDTH),
		.MAX_LOCAL_PORTS(MAX_LOCAL_PORTS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.delta_x(s_tdata[9:0]),
		.delta_y(s_tdata[19:10]),
		.accept(push),
		.entry(entry)
	);

	tarr_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_entry(entry),
		.full(full),
		.pop(pop),
		.head_valid(head_valid),
		.head(head)
	);

	tarr_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_valid(head_valid),
		.head(head),
		.pop(pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.m_tuser(m_tuser)
	);

endmodule

FILE: hdl/tarr_checker.sv
module tarr_checker import tarr_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata,
	input logic        m_tlast,
	input logic        m_tuser
);

	a_rst_quiet: assert property (@(posedge clk) !arst_n |-> !m_tvalid)
		else $error("output valid during reset");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
			&& $stable(m_tuser))
		else $error("stalled item changed");

	a_none: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast && m_tdata == 8'd0)
		else $error("empty-list item malformed");

	a_local: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2:0] == PORT_LOCAL |-> m_tlast && !m_tuser
			&& m_tdata[7:3] != 5'd0)
		else $error("local request not alone");

	a_port: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[2:0] <= PORT_LOCAL)
		else $error("port code out of range");

endmodule

bind torus_adaptive_route_request_core tarr_checker u_chk (.*);

FILE: verif/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tarr_pkg::*;

	localparam int COORD_W   = 8;
	localparam int MAX_LOCAL = 16;
	localparam logic [1:0] CLS_OFF = 2'd0;  // adaptive requests only, no escape
	localparam int PRINT_CAP = 100;

	typedef struct packed {
		logic       none;
		logic       last;
		logic [4:0] chan;
		logic [2:0] port;
	} route_req_t;

	localparam route_req_t NIL      = '0;
	localparam route_req_t NO_ROUTE = '{none: 1'b1, last: 1'b1, chan: 5'd0, port: 3'd0};

	typedef enum {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t         kind;
		reg_idx_t          idx;
		logic [7:0]        val;
		logic signed [9:0] dx;
		logic signed [9:0] dy;
		int                n_typed;
		route_req_t        typed [4];
	} dir_row_t;

	logic        clk;
	logic        arst_n    = 1'b1;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata   = '0;  // delta_x, delta_y, zero pad
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [7:0]  m_tdata;         // out_port, out_channel
	logic        m_tlast;
	logic        m_tuser;         // no_request
	logic        cfg_wr_en = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [7:0]  cfg_data  = '0;

	// block state as the checker sees it
	int cur_class  = CLS_ADAPTIVE;
	int cur_rx     = 0;
	int cur_ry     = 0;
	int cur_radius = 7;
	int cur_lpc    = 1;
	int consumer_ptr = 0;

	route_req_t route_list[$];
	route_req_t pending_reqs[$];
	route_req_t blank_typed [4] = '{default: NIL};
	dir_row_t   dir_tbl[];

	bit idle_s = 1'b1;
	bit idle_m = 1'b1;
	int fail_count = 0;
	int n_headers  = 0;
	int n_reqs     = 0;
	int n_settings = 1;

	torus_adaptive_route_request_core #(
		.COORD_WIDTH(COORD_W),
		.MAX_LOCAL_PORTS(MAX_LOCAL)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.m_tuser(m_tuser),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("TB_ERROR");
		$finish;
	end

	function automatic route_req_t rq(logic [2:0] p, logic [4:0] c);
		route_req_t r;
		r = '0;
		r.port = p;
		r.chan = c;
		return r;
	endfunction

	function automatic void add_req(logic [2:0] p, logic [4:0] c);
		route_list.push_back(rq(p, c));
	endfunction

	// L is only offered when the destination stays on this side of the wrap link
	function automatic bit fits_ring(int d, int coord);
		return (d + coord >= 0) && (d + coord <= cur_radius);
	endfunction

	// fills route_list with the requests one header produces
	function automatic void route_header(logic signed [9:0] dx, logic signed [9:0] dy);
		int sx, sy, ax, ay, cnt;
		logic [2:0] px, py;
		sx = dx;
		sy = dy;
		ax = (sx < 0) ? -sx : sx;
		ay = (sy < 0) ? -sy : sy;
		px = (sx > 0) ? PORT_XP : PORT_XM;
		py = (sy > 0) ? PORT_YP : PORT_YM;
		route_list.delete();
		if (ax == 1 && ay == 1) begin
			cnt = (cur_lpc > MAX_LOCAL) ? MAX_LOCAL : cur_lpc;
			if (consumer_ptr >= cnt)
				consumer_ptr = 0;
			consumer_ptr++;
			add_req(PORT_LOCAL, 5'(consumer_ptr));
		end else begin
			if (ax > 1)
				add_req(px, VC_ADAPTIVE);
			if (ay > 1)
				add_req(py, VC_ADAPTIVE);
			if (cur_class != CLS_OFF) begin
				if (ax > 1) begin
					// escape-L input on X: L then H, no wrap check
					if (cur_class == CLS_ESC_L) begin
						add_req(px, VC_L);
						add_req(px, VC_H);
					end else begin
						add_req(px, VC_H);
						if (fits_ring(sx, cur_rx))
							add_req(px, VC_L);
					end
				end else if (ax == 1 && ay > 1) begin
					add_req(py, VC_H);
					if (fits_ring(sy, cur_ry))
						add_req(py, VC_L);
				end
			end
		end
		if (route_list.size() == 0)
			route_list.push_back(NO_ROUTE);
		route_list[route_list.size() - 1].last = 1'b1;
	endfunction

	task automatic write_reg(reg_idx_t idx, logic [7:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			REG_CLASS:  cur_class  = val[1:0];
			REG_RX:     cur_rx     = val;
			REG_RY:     cur_ry     = val;
			REG_RADIUS: cur_radius = val;
			REG_LPC:    cur_lpc    = val[4:0];
			default: ;
		endcase
	endtask

	task automatic drain_requests();
		s_tvalid <= 1'b0;
		while (pending_reqs.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic send_header(logic signed [9:0] dx, logic signed [9:0] dy, int n_typed,
			route_req_t typed [4]);
		int gap;
		gap = idle_s ? $urandom_range(0, 8) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {4'b0, dy, dx};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		route_header(dx, dy);  // always run: keeps the consumer pointer in step
		if (n_typed > 0) begin
			route_list.delete();
			for (int i = 0; i < n_typed; i++)
				route_list.push_back(typed[i]);
			route_list[n_typed - 1].last = 1'b1;
		end
		foreach (route_list[i])
			pending_reqs.push_back(route_list[i]);
		n_headers++;
	endtask

	function automatic logic [7:0] corner_byte();
		case ($urandom_range(0, 3))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic signed [9:0] unit_delta();
		return $urandom_range(0, 1) ? 10'sd1 : -10'sd1;
	endfunction

	// lands the destination around 0..radius so the wrap check flips both ways
	function automatic logic signed [9:0] ring_delta(int coord);
		return 10'($urandom_range(0, cur_radius + 4) - coord - 2);
	endfunction

	function automatic void random_delta(output logic signed [9:0] dx,
			output logic signed [9:0] dy);
		case ($urandom_range(0, 9))
			0, 1: begin
				dx = unit_delta();
				dy = unit_delta();
			end
			2: begin
				dx = unit_delta();
				dy = ring_delta(cur_ry);
			end
			3: begin
				dx = ring_delta(cur_rx);
				dy = unit_delta();
			end
			4, 5, 6: begin
				dx = ring_delta(cur_rx);
				dy = ring_delta(cur_ry);
			end
			7: begin
				dx = 10'($urandom_range(0, 2) - 1);
				dy = 10'($urandom_range(0, 2) - 1);
			end
			default: begin
				dx = 10'($urandom_range(0, 1023));
				dy = 10'($urandom_range(0, 1023));
			end
		endcase
	endfunction

	task automatic note_mismatch(string what, int exp_v, int act_v);
		fail_count++;
		if (fail_count <= PRINT_CAP)
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, what, exp_v, act_v);
	endtask

	// result side: random stalls, compare with the oldest expected request
	initial begin
		int gap;
		route_req_t want;
		forever begin
			gap = idle_m ? $urandom_range(0, 8) : 0;
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid)
				@(posedge clk);
			n_reqs++;
			if (pending_reqs.size() == 0) begin
				fail_count++;
				$display("%0t: request with nothing expected, expected none, got port %0d chan %0d",
					$time, m_tdata[2:0], m_tdata[7:3]);
			end else begin
				want = pending_reqs.pop_front();
				if (m_tdata[2:0] != want.port)
					note_mismatch("out_port", want.port, m_tdata[2:0]);
				if (m_tdata[7:3] != want.chan)
					note_mismatch("out_channel", want.chan, m_tdata[7:3]);
				if (m_tlast != want.last)
					note_mismatch("is_last", want.last, m_tlast);
				if (m_tuser != want.none)
					note_mismatch("no_request", want.none, m_tuser);
			end
		end
	end

	initial begin
		logic signed [9:0] dx, dy;
		bit in_cfg;
		int n_directed;
		// falling edge at time zero so the asynchronous reset takes hold at once
		arst_n <= 1'b0;
		in_cfg = 1'b0;
		dir_tbl = '{
			// reset settings: class adaptive, origin, radius 7, one consumer
			'{ROW_ITEM, REG_CLASS, 8'd0, 0, 0, 1, '{NO_ROUTE, NIL, NIL, NIL}},
			'{ROW_ITEM, REG_CLASS, 8'd0, 1, 1, 1, '{rq(PORT_LOCAL, 5'd1), NIL, NIL, NIL}},
			'{ROW_ITEM, REG_CLASS, 8'd0, -1, 1, 1, '{rq(PORT_LOCAL, 5'd1), NIL, NIL, NIL}},
			'{ROW_ITEM, REG_CLASS, 8'd0, 3, 0, 3,
				'{rq(PORT_XP, VC_ADAPTIVE), rq(PORT_XP, VC_H), rq(PORT_XP, VC_L), NIL}},
			'{ROW_ITEM, REG_CLASS, 8'd0, -3, 0, 2,
				'{rq(PORT_XM, VC_ADAPTIVE), rq(PORT_XM, VC_H), NIL, NIL}},
			'{ROW_ITEM, REG_CLASS, 8'd0, 1, 5, 3,
				'{rq(PORT_YP, VC_ADAPTIVE), rq(PORT_YP, VC_H), rq(PORT_YP, VC_L), NIL}},
			'{ROW_ITEM, REG_CLASS, 8'd0, 511, -512, 3,
				'{rq(PORT_XP, VC_ADAPTIVE), rq(PORT_YM, VC_ADAPTIVE), rq(PORT_XP, VC_H), NIL}},
			'{ROW_ITEM, REG_CLASS, 8'd0, -512, 511, 0, '{default: NIL}},
			'{ROW_ITEM, REG_CLASS, 8'd0, 0, 1, 1, '{NO_ROUTE, NIL, NIL, NIL}},
			'{ROW_ITEM, REG_CLASS, 8'd0, 1, 0, 1, '{NO_ROUTE, NIL, NIL, NIL}},
			'{ROW_ITEM, REG_CLASS, 8'd0, 0, 4, 0, '{default: NIL}},
			'{ROW_ITEM, REG_CLASS, 8'd0, -1, -7, 0, '{default: NIL}},
			'{ROW_ITEM, REG_CLASS, 8'd0, 2, 2, 0, '{default: NIL}},
			// no escape channels
			'{ROW_CFG, REG_CLASS, 8'(CLS_OFF), 0, 0, 0, '{default: NIL}},
			'{ROW_ITEM, REG_CLASS, 8'd0, 5, -5, 2,
				'{rq(PORT_XP, VC_ADAPTIVE), rq(PORT_YM, VC_ADAPTIVE), NIL, NIL}},
			'{ROW_ITEM, REG_CLASS, 8'd0, -1, 0, 1, '{NO_ROUTE, NIL, NIL, NIL}},
			'{ROW_ITEM, REG_CLASS, 8'd0, 1, 1, 0, '{default: NIL}},
			'{ROW_ITEM, REG_CLASS, 8'd0, 1, 6, 1, '{rq(PORT_YP, VC_ADAPTIVE), NIL, NIL, NIL}},
			// escape L, far corner, widest ring, zero consumers
			'{ROW_CFG, REG_CLASS, 8'(CLS_ESC_L), 0, 0, 0, '{default: NIL}},
			'{ROW_CFG, REG_RX, 8'd255, 0, 0, 0, '{default: NIL}},
			'{ROW_CFG, REG_RY, 8'd255, 0, 0, 0, '{default: NIL}},
			'{ROW_CFG, REG_RADIUS, 8'd255, 0, 0, 0, '{default: NIL}},
			'{ROW_CFG, REG_LPC, 8'd0, 0, 0, 0, '{default: NIL}},
			'{ROW_ITEM, REG_CLASS, 8'd0, 4, 3, 4,
				'{rq(PORT_XP, VC_ADAPTIVE), rq(PORT_YP, VC_ADAPTIVE), rq(PORT_XP, VC_L),
				rq(PORT_XP, VC_H)}},
			'{ROW_ITEM, REG_CLASS, 8'd0, 1, -200, 0, '{default: NIL}},
			'{ROW_ITEM, REG_CLASS, 8'd0, -1, -1, 1, '{rq(PORT_LOCAL, 5'd1), NIL, NIL, NIL}},
			'{ROW_ITEM, REG_CLASS, 8'd0, -9, 0, 0, '{default: NIL}},
			// escape H, origin, zero radius, consumer count above the clamp
			'{ROW_CFG, REG_CLASS, 8'(CLS_ESC_H), 0, 0, 0, '{default: NIL}},
			'{ROW_CFG, REG_RX, 8'd0, 0, 0, 0, '{default: NIL}},
			'{ROW_CFG, REG_RY, 8'd0, 0, 0, 0, '{default: NIL}},
			'{ROW_CFG, REG_RADIUS, 8'd0, 0, 0, 0, '{default: NIL}},
			'{ROW_CFG, REG_LPC, 8'hFF, 0, 0, 0, '{default: NIL}},
			'{ROW_ITEM, REG_CLASS, 8'd0, -1, 1, 0, '{default: NIL}},
			'{ROW_ITEM, REG_CLASS, 8'd0, 1, -1, 0, '{default: NIL}},
			'{ROW_ITEM, REG_CLASS, 8'd0, -1, 2, 0, '{default: NIL}},
			'{ROW_ITEM, REG_CLASS, 8'd0, 1, 1, 0, '{default: NIL}}
		};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (dir_tbl[r]) begin
			if (dir_tbl[r].kind == ROW_CFG) begin
				if (!in_cfg) begin
					drain_requests();
					n_settings++;
				end
				write_reg(dir_tbl[r].idx, dir_tbl[r].val);
				in_cfg = 1'b1;
			end else begin
				if (in_cfg)
					cfg_wr_en <= 1'b0;
				in_cfg = 1'b0;
				send_header(dir_tbl[r].dx, dir_tbl[r].dy, dir_tbl[r].n_typed, dir_tbl[r].typed);
			end
		end
		n_directed = n_headers;

		// each class twice; low class bits fixed, upper data bits random
		for (int ph = 0; ph < 8; ph++) begin
			drain_requests();
			n_settings++;
			idle_s = ($urandom_range(0, 3) != 0);
			idle_m = ($urandom_range(0, 3) != 0);
			write_reg(REG_CLASS, {6'($urandom_range(0, 63)), 2'(ph)});
			write_reg(REG_RX, corner_byte());
			write_reg(REG_RY, corner_byte());
			write_reg(REG_RADIUS, corner_byte());
			write_reg(REG_LPC, 8'($urandom_range(0, 255)));
			cfg_wr_en <= 1'b0;
			repeat (25) begin
				random_delta(dx, dy);
				send_header(dx, dy, 0, blank_typed);
			end
		end

		s_tvalid <= 1'b0;
		for (int w = 0; w < 4000 && pending_reqs.size() != 0; w++)
			@(posedge clk);
		if (pending_reqs.size() != 0) begin
			fail_count++;
			$display("%0t: %0d requests never arrived", $time, pending_reqs.size());
		end
		repeat (10) @(posedge clk);

		$display("Routed %0d headers (%0d directed) under %0d register settings,",
			n_headers, n_directed, n_settings);
		$display("checked %0d requests, %0d mismatches.", n_reqs, fail_count);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
